/* hdl/spelled_callsign_decoder_assert.svh */
// assertion macros used by the callsign decoder checker
`ifndef SPELLED_CALLSIGN_DECODER_ASSERT_SVH
`define SPELLED_CALLSIGN_DECODER_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define SCD_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define SCD_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/scd_pkg.sv */
// shared types, character codes and spelling dictionary of the callsign decoder
package scd_pkg;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DASH  = 8'h2d;

  localparam int DICT_SIZE  = 48;
  localparam int DICT_CHARS = 8;

  // what the front hands to the back for one input beat
  typedef enum logic [1:0] {
    CMD_STREAM,
    CMD_OVERFLOW,
    CMD_FINISH,
    CMD_FIN_LONG
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic       eos;
    logic [7:0] ch;
  } cmd_ctl_t;

  // word is right-justified, first letter in the highest used byte
  typedef struct packed {
    logic [8*DICT_CHARS-1:0] word;
    logic [3:0]              len;
    logic [7:0]              sym;
  } dict_entry_t;

  localparam dict_entry_t DICT [DICT_SIZE] = '{
    '{"alfa", 4'd4, "A"}, '{"alpha", 4'd5, "A"}, '{"bravo", 4'd5, "B"},
    '{"charlie", 4'd7, "C"}, '{"delta", 4'd5, "D"}, '{"echo", 4'd4, "E"},
    '{"foxtrot", 4'd7, "F"}, '{"golf", 4'd4, "G"}, '{"hotel", 4'd5, "H"},
    '{"india", 4'd5, "I"}, '{"juliett", 4'd7, "J"}, '{"kilo", 4'd4, "K"},
    '{"lima", 4'd4, "L"}, '{"mike", 4'd4, "M"}, '{"november", 4'd8, "N"},
    '{"oscar", 4'd5, "O"}, '{"papa", 4'd4, "P"}, '{"quebec", 4'd6, "Q"},
    '{"romeo", 4'd5, "R"}, '{"sierra", 4'd6, "S"}, '{"tango", 4'd5, "T"},
    '{"uniform", 4'd7, "U"}, '{"victor", 4'd6, "V"}, '{"whiskey", 4'd7, "W"},
    '{"xray", 4'd4, "X"}, '{"yankee", 4'd6, "Y"}, '{"zulu", 4'd4, "Z"},
    '{"zero", 4'd4, "0"}, '{"one", 4'd3, "1"}, '{"two", 4'd3, "2"},
    '{"three", 4'd5, "3"}, '{"four", 4'd4, "4"}, '{"five", 4'd4, "5"},
    '{"six", 4'd3, "6"}, '{"seven", 4'd5, "7"}, '{"eight", 4'd5, "8"},
    '{"nine", 4'd4, "9"}, '{"niner", 4'd5, "9"},
    '{"0", 4'd1, "0"}, '{"1", 4'd1, "1"}, '{"2", 4'd1, "2"}, '{"3", 4'd1, "3"},
    '{"4", 4'd1, "4"}, '{"5", 4'd1, "5"}, '{"6", 4'd1, "6"}, '{"7", 4'd1, "7"},
    '{"8", 4'd1, "8"}, '{"9", 4'd1, "9"}
  };

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    if (c >= "A" && c <= "Z") begin
      return c + 8'd32;
    end
    return c;
  endfunction

  // returns the decoded symbol, zero when the token is not in the dictionary
  function automatic logic [7:0] dict_lookup(input logic [DICT_CHARS-1:0][7:0] tok,
                                             input logic [4:0] len);
    logic [7:0]              sym;
    logic                    hit;
    logic [8*DICT_CHARS-1:0] lw;
    sym = '0;
    for (int i = 0; i < DICT_SIZE; i++) begin
      lw  = DICT[i].word << (8 * (DICT_CHARS - int'(DICT[i].len)));
      hit = ({1'b0, DICT[i].len} == len);
      for (int k = 0; k < DICT_CHARS; k++) begin
        if (k < int'(DICT[i].len) &&
            fold_case(tok[k]) != lw[8*(DICT_CHARS-1-k) +: 8]) begin
          hit = 1'b0;
        end
      end
      if (hit) begin
        sym = DICT[i].sym;
      end
    end
    return sym;
  endfunction

endpackage

/* hdl/scd_queue.sv */
// command queue between the front and the back of the callsign decoder
module scd_queue #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wptr_r, wptr_nxt;
  logic [PW-1:0]    rptr_r, rptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  assign full     = (cnt_r == CW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + PW'(1);
    end
    if (pop) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

endmodule

/* hdl/scd_front.sv */
// input side of the callsign decoder: token buffering and classification
module scd_front import scd_pkg::*; #(
  parameter int WORD_CHARS = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [7:0]                         in_char_in,
  input  logic                               in_last_char,
  input  logic                               q_full,
  output logic                               cmd_push,
  output cmd_ctl_t                           cmd_ctl,
  output logic [WORD_CHARS-1:0][7:0]         cmd_buf,
  output logic [$clog2(WORD_CHARS+1)-1:0]    cmd_len
);

  localparam int LW = $clog2(WORD_CHARS + 1);
  localparam int IW = $clog2(WORD_CHARS);

  logic [WORD_CHARS-1:0][7:0] buf_r, buf_nxt;
  logic [LW-1:0]              len_r, len_nxt;
  logic                       long_r, long_nxt;
  logic                       aft_r, aft_nxt;
  logic                       accept;
  cmd_kind_t                  kind;
  logic [LW-1:0]              tok_len;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    buf_nxt  = buf_r;
    len_nxt  = len_r;
    long_nxt = long_r;
    aft_nxt  = aft_r;
    cmd_push = 1'b0;
    kind     = CMD_FINISH;
    tok_len  = len_r;
    if (accept) begin
      if (!aft_r) begin
        if (in_char_in == CH_SPACE) begin
          aft_nxt = 1'b1;
        end else if (in_char_in == CH_DASH) begin
          cmd_push = 1'b1;
          kind     = long_r ? CMD_FIN_LONG : CMD_FINISH;
          len_nxt  = '0;
          long_nxt = 1'b0;
        end else if (long_r) begin
          cmd_push = 1'b1;
          kind     = CMD_STREAM;
        end else if (len_r < LW'(WORD_CHARS)) begin
          buf_nxt[len_r[IW-1:0]] = in_char_in;
          len_nxt                = len_r + LW'(1);
        end else begin
          cmd_push = 1'b1;
          kind     = CMD_OVERFLOW;
          long_nxt = 1'b1;
        end
      end
      if (in_last_char) begin
        if (!cmd_push) begin
          // token closed by the final character itself
          cmd_push = 1'b1;
          kind     = long_nxt ? CMD_FIN_LONG : CMD_FINISH;
          tok_len  = len_nxt;
        end
        len_nxt  = '0;
        long_nxt = 1'b0;
        aft_nxt  = 1'b0;
      end
    end
  end

  assign cmd_ctl.kind = kind;
  assign cmd_ctl.eos  = in_last_char;
  assign cmd_ctl.ch   = in_char_in;
  assign cmd_buf      = buf_nxt;
  assign cmd_len      = tok_len;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= '0;
      long_r <= 1'b0;
      aft_r  <= 1'b0;
    end else begin
      len_r  <= len_nxt;
      long_r <= long_nxt;
      aft_r  <= aft_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
  end

endmodule

/* hdl/scd_back.sv */
// output side of the callsign decoder: dictionary match and beat sequencing
module scd_back import scd_pkg::*; #(
  parameter int WORD_CHARS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_empty,
  output logic                            q_pop,
  input  cmd_ctl_t                        q_ctl,
  input  logic [WORD_CHARS-1:0][7:0]      q_buf,
  input  logic [$clog2(WORD_CHARS+1)-1:0] q_len,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [7:0]                      out_char_out,
  output logic                            out_char_valid,
  output logic                            out_end_of_string
);

  localparam int LW = $clog2(WORD_CHARS + 1);
  localparam int IW = $clog2(WORD_CHARS);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_LOOK = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t                     st_r, st_nxt;
  cmd_ctl_t                   ctl_r, ctl_nxt;
  logic [WORD_CHARS-1:0][7:0] cbuf_r, cbuf_nxt;
  logic [LW-1:0]              clen_r, clen_nxt;
  logic                       pe_r, pe_nxt;
  logic                       le_r, le_nxt;
  logic [LW-1:0]              nb_r, nb_nxt;
  logic [LW-1:0]              idx_r, idx_nxt;
  logic                       te_r, te_nxt;
  logic [7:0]                 tc_r, tc_nxt;
  logic                       eos_r, eos_nxt;
  logic                       pend_r, pend_nxt;
  logic                       started_r, started_nxt;
  logic                       ov_r, ov_nxt;
  logic [7:0]                 oc_r, oc_nxt;
  logic                       ocv_r, ocv_nxt;
  logic                       oe_r, oe_nxt;
  logic [DICT_CHARS-1:0][7:0] look_w;
  logic [7:0]                 sym;
  logic                       any;
  logic                       more;

  always_comb begin
    for (int k = 0; k < DICT_CHARS; k++) begin
      look_w[k] = cbuf_r[k];
    end
  end

  assign sym = dict_lookup(look_w, 5'(clen_r));

  always_comb begin
    st_nxt      = st_r;
    ctl_nxt     = ctl_r;
    cbuf_nxt    = cbuf_r;
    clen_nxt    = clen_r;
    pe_nxt      = pe_r;
    le_nxt      = le_r;
    nb_nxt      = nb_r;
    idx_nxt     = idx_r;
    te_nxt      = te_r;
    tc_nxt      = tc_r;
    eos_nxt     = eos_r;
    pend_nxt    = pend_r;
    started_nxt = started_r;
    ov_nxt      = ov_r;
    oc_nxt      = oc_r;
    ocv_nxt     = ocv_r;
    oe_nxt      = oe_r;
    q_pop       = 1'b0;
    any         = 1'b0;
    more        = 1'b0;

    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end

    unique case (st_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          ctl_nxt  = q_ctl;
          cbuf_nxt = q_buf;
          clen_nxt = q_len;
          st_nxt   = ST_LOOK;
        end
      end
      ST_LOOK: begin
        pe_nxt  = 1'b0;
        le_nxt  = 1'b0;
        nb_nxt  = '0;
        te_nxt  = 1'b0;
        tc_nxt  = ctl_r.ch;
        idx_nxt = '0;
        eos_nxt = ctl_r.eos;
        unique case (ctl_r.kind)
          CMD_STREAM: begin
            te_nxt = 1'b1;
          end
          CMD_OVERFLOW: begin
            pe_nxt      = pend_r;
            le_nxt      = started_r;
            nb_nxt      = LW'(WORD_CHARS);
            te_nxt      = 1'b1;
            pend_nxt    = 1'b0;
            started_nxt = 1'b1;
          end
          CMD_FIN_LONG: begin
            pend_nxt = 1'b1;
          end
          CMD_FINISH: begin
            if (clen_r != '0) begin
              pe_nxt      = pend_r;
              started_nxt = 1'b1;
              if (sym != '0) begin
                te_nxt   = 1'b1;
                tc_nxt   = sym;
                pend_nxt = 1'b0;
              end else begin
                le_nxt   = started_r;
                nb_nxt   = clen_r;
                pend_nxt = 1'b1;
              end
            end
          end
        endcase
        any = pe_nxt || le_nxt || (nb_nxt != '0) || te_nxt;
        if (ctl_r.eos) begin
          pend_nxt    = 1'b0;
          started_nxt = 1'b0;
        end
        st_nxt = (any || ctl_r.eos) ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (!ov_r || out_ready) begin
          ov_nxt  = 1'b1;
          ocv_nxt = 1'b1;
          if (pe_r) begin
            oc_nxt = CH_SPACE;
            pe_nxt = 1'b0;
            more   = le_r || (idx_r < nb_r) || te_r;
          end else if (le_r) begin
            oc_nxt = CH_SPACE;
            le_nxt = 1'b0;
            more   = (idx_r < nb_r) || te_r;
          end else if (idx_r < nb_r) begin
            oc_nxt  = cbuf_r[idx_r[IW-1:0]];
            idx_nxt = idx_r + LW'(1);
            more    = ((idx_r + LW'(1)) < nb_r) || te_r;
          end else if (te_r) begin
            oc_nxt = tc_r;
            te_nxt = 1'b0;
          end else begin
            // bare end marker, nothing else came out of this string end
            oc_nxt  = '0;
            ocv_nxt = 1'b0;
          end
          oe_nxt = eos_r && !more;
          if (!more) begin
            st_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_IDLE;
      pend_r    <= 1'b0;
      started_r <= 1'b0;
      ov_r      <= 1'b0;
      pe_r      <= 1'b0;
      le_r      <= 1'b0;
      te_r      <= 1'b0;
      nb_r      <= '0;
      idx_r     <= '0;
      eos_r     <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      pend_r    <= pend_nxt;
      started_r <= started_nxt;
      ov_r      <= ov_nxt;
      pe_r      <= pe_nxt;
      le_r      <= le_nxt;
      te_r      <= te_nxt;
      nb_r      <= nb_nxt;
      idx_r     <= idx_nxt;
      eos_r     <= eos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ctl_r  <= ctl_nxt;
    cbuf_r <= cbuf_nxt;
    clen_r <= clen_nxt;
    tc_r   <= tc_nxt;
    oc_r   <= oc_nxt;
    ocv_r  <= ocv_nxt;
    oe_r   <= oe_nxt;
  end

  assign out_valid         = ov_r;
  assign out_char_out      = oc_r;
  assign out_char_valid    = ocv_r;
  assign out_end_of_string = oe_r;

endmodule

/* hdl/spelled_callsign_decoder.sv */
// top level of the spelled callsign decoder
// Turns a spoken callsign ("november-one-two-three-alfa"), fed one ASCII
// character per input beat with in_last_char on the final character, back
// into its characters ("N123A"). Everything from the first space on is
// ignored, tokens are cut at dashes, empty tokens are skipped, and a token
// that is a spelling-alphabet word, number word or single digit (any case)
// becomes one character. Unknown tokens are copied with spaces around them,
// the trailing space never comes out, and tokens longer than WORD_CHARS
// stream through as they arrive. Each string ends with a result beat that
// has out_end_of_string set; a string that produces nothing yields one bare
// beat with out_char_valid low. Timing: the front takes one input beat per
// cycle as long as its 4-entry command queue has room; a beat that only
// extends the current token loads nothing into the queue. A beat that
// closes or streams a token becomes a command; the back dequeues it, then
// matches it against the dictionary, then sends its result beats. The
// command queue decouples the two sides, so input keeps flowing while a
// result waits to be taken, until the queue is full.
module spelled_callsign_decoder import scd_pkg::*; #(
  parameter int WORD_CHARS = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char_in,
  input  logic       in_last_char,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char_out,
  output logic       out_char_valid,
  output logic       out_end_of_string
);

  localparam int LW          = $clog2(WORD_CHARS + 1);
  localparam int QUEUE_DEPTH = 4;
  localparam int QW          = $bits(cmd_ctl_t) + 8 * WORD_CHARS + LW;

  // front to queue
  logic                       cmd_push;
  cmd_ctl_t                   cmd_ctl;
  logic [WORD_CHARS-1:0][7:0] cmd_buf;
  logic [LW-1:0]              cmd_len;

  // queue to back
  logic                       q_full;
  logic                       q_empty;
  logic                       q_pop;
  logic [QW-1:0]              q_data;
  cmd_ctl_t                   q_ctl;
  logic [WORD_CHARS-1:0][7:0] q_buf;
  logic [LW-1:0]              q_len;

  // front: holds the token being spelled and decides what each beat means
  scd_front #(
    .WORD_CHARS (WORD_CHARS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char_in   (in_char_in),
    .in_last_char (in_last_char),
    .q_full       (q_full),
    .cmd_push     (cmd_push),
    .cmd_ctl      (cmd_ctl),
    .cmd_buf      (cmd_buf),
    .cmd_len      (cmd_len)
  );

  // commands carry a snapshot of the token so the front can move on
  scd_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_data ({cmd_ctl, cmd_buf, cmd_len}),
    .pop       (q_pop),
    .pop_data  (q_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  assign {q_ctl, q_buf, q_len} = q_data;

  // back: dictionary match, spacing state and result beats
  scd_back #(
    .WORD_CHARS (WORD_CHARS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_pop             (q_pop),
    .q_ctl             (q_ctl),
    .q_buf             (q_buf),
    .q_len             (q_len),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_char_out      (out_char_out),
    .out_char_valid    (out_char_valid),
    .out_end_of_string (out_end_of_string)
  );

endmodule

/* hdl/scd_checker.sv */
// port-level checks of the callsign decoder and their bind to the top level
`include "spelled_callsign_decoder_assert.svh"

module scd_checker import scd_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char_out,
  input logic       out_char_valid,
  input logic       out_end_of_string
);

  logic       out_stall;
  logic [9:0] out_beat;
  logic       out_bare;
  logic       out_last_char;

  assign out_stall     = out_valid && !out_ready;
  assign out_beat      = {out_char_out, out_char_valid, out_end_of_string};
  assign out_bare      = out_valid && !out_char_valid;
  assign out_last_char = out_valid && out_end_of_string && out_char_valid;

  // a stalled result beat stays up
  `SCD_ASSERT_NEXT(a_out_hold, out_stall, out_valid, "result beat dropped")

  // and keeps its payload
  `SCD_ASSERT_NEXT(a_out_stable, out_stall, $stable(out_beat), "stalled result changed")

  // a beat without a character only ever closes a string
  `SCD_ASSERT_IMPL(a_bare_is_end, out_bare, out_end_of_string, "bare beat not at end")

  // the last character of a string is never a space
  `SCD_ASSERT_IMPL(a_no_trailing_space, out_last_char, out_char_out != CH_SPACE, "trailing space sent")

endmodule

bind spelled_callsign_decoder scd_checker u_scd_checker (.*);
